@@ rtl/core/pnm_hdr_pkg.sv @@
// ----------------------------------------------------------------------------
// pnm_hdr_pkg
// Types and constants shared by the PNM header parser modules.
// ----------------------------------------------------------------------------
package pnm_hdr_pkg;

  // Width of the dimension fields on the result port
  localparam int unsigned DIM_OUT_W = 16;

  // Characters the parser looks for
  localparam logic [7:0] CH_P     = 8'h50;  // 'P'
  localparam logic [7:0] CH_HASH  = 8'h23;  // '#'
  localparam logic [7:0] CH_LF    = 8'h0A;  // newline
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_0     = 8'h30;  // '0'
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_2     = 8'h32;
  localparam logic [7:0] CH_3     = 8'h33;
  localparam logic [7:0] CH_4     = 8'h34;
  localparam logic [7:0] CH_5     = 8'h35;
  localparam logic [7:0] CH_6     = 8'h36;
  localparam logic [7:0] CH_9     = 8'h39;  // '9'

  // Input item kind
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_EOD  = 1'b1;

  typedef enum logic [1:0] {
    ST_UNDECIDED = 2'd0,
    ST_GOOD      = 2'd1,
    ST_BAD       = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    IMG_UNKNOWN = 2'd0,
    IMG_BITMAP  = 2'd1,
    IMG_GRAYMAP = 2'd2,
    IMG_PIXMAP  = 2'd3
  } img_type_e;

  typedef enum logic [2:0] {
    PH_MAGIC      = 3'd0,  // expect 'P'
    PH_TYPE       = 3'd1,  // expect type digit
    PH_GAP1       = 3'd2,  // expect first whitespace
    PH_GAP1_MORE  = 3'd3,  // whitespace or first width digit
    PH_WIDTH      = 3'd4,  // width digits
    PH_GAP2       = 3'd5,  // whitespace or first height digit
    PH_HEIGHT     = 3'd6   // height digits
  } phase_e;

  // Control part of the parser state
  typedef struct packed {
    phase_e    phase;
    logic      in_comment;
    status_e   verdict;
    img_type_e type_code;
  } hdr_ctrl_t;

  // One result transaction
  typedef struct packed {
    status_e              status;
    img_type_e            image_type;
    logic [DIM_OUT_W-1:0] image_width;
    logic [DIM_OUT_W-1:0] image_height;
  } hdr_result_t;

endpackage

@@ rtl/core/pnm_header_dimension_parser_top.sv @@
// ----------------------------------------------------------------------------
// pnm_header_dimension_parser_top
// Streaming parser for the magic, type, width and height of a PNM header.
// ----------------------------------------------------------------------------
// Input channel: one transaction per file byte (kind_i = 0, data_byte_i) or an
// end-of-data mark (kind_i = 1). Each accepted transaction yields exactly one
// result transaction carrying status, image type, width and height as they
// stand after that byte. Status turns good once the whitespace after the
// height is seen, bad on any unexpected byte or on end of data before then;
// after that the parser holds and echoes the same result for later input.
// Throughput is one transaction per cycle while in_stall_o is low. Results go
// to the result register, through the skid entry while that register is held.
// The next-state logic is a single pass over the parser state plus one shared
// times-ten adder, so no item waits on another. The two-entry output lets the
// input take one more transaction after the receiver raises out_stall_i;
// in_stall_o rises only when both entries are full, and is a register output.
// Reset (rst_ni low, asynchronous) returns the parser to expecting 'P',
// clears width/height to zero and drops any pending result.
// Start a new file by resetting the block.
// ----------------------------------------------------------------------------
module pnm_header_dimension_parser_top #(
  parameter int unsigned DIM_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [1:0]  image_type_o,
  output logic [15:0] image_width_o,
  output logic [15:0] image_height_o
);
  import pnm_hdr_pkg::*;

  // parser state
  hdr_ctrl_t           ctrl_q, ctrl_d;
  logic [DIM_BITS-1:0] width_acc_q, width_acc_d;
  logic [DIM_BITS-1:0] height_acc_q, height_acc_d;

  // output register and skid entry
  logic        out_valid_q, out_valid_d;
  logic        skid_valid_q, skid_valid_d;
  hdr_result_t out_q, out_d;
  hdr_result_t skid_q, skid_d;
  hdr_result_t new_result;

  logic in_accept;
  logic out_free;

  assign in_accept = in_valid_i & ~skid_valid_q;
  // result register empties this cycle or is already empty
  assign out_free  = ~out_valid_q | ~out_stall_i;

  pnm_hdr_step #(
    .DIM_BITS(DIM_BITS)
  ) u_step (
    .ctrl_i      (ctrl_q),
    .width_acc_i (width_acc_q),
    .height_acc_i(height_acc_q),
    .kind_i      (kind_i),
    .data_byte_i (data_byte_i),
    .ctrl_o      (ctrl_d),
    .width_acc_o (width_acc_d),
    .height_acc_o(height_acc_d)
  );

  // Result shows the state after the step; dimensions cut or padded to port width
  always_comb begin
    new_result.status       = ctrl_d.verdict;
    new_result.image_type   = ctrl_d.type_code;
    new_result.image_width  = DIM_OUT_W'(width_acc_d);
    new_result.image_height = DIM_OUT_W'(height_acc_d);
  end

  // Output queue control: skid drains first, new results go to the free slot
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (out_free) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end
    end else if (out_free) begin
      out_valid_d = in_accept;
      out_d       = new_result;
    end else if (in_accept) begin
      skid_d       = new_result;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q       <= '{phase: PH_MAGIC, in_comment: 1'b0,
                        verdict: ST_UNDECIDED, type_code: IMG_UNKNOWN};
      width_acc_q  <= '0;
      height_acc_q <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        ctrl_q       <= ctrl_d;
        width_acc_q  <= width_acc_d;
        height_acc_q <= height_acc_d;
      end
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign in_stall_o     = skid_valid_q;
  assign out_valid_o    = out_valid_q;
  assign status_o       = out_q.status;
  assign image_type_o   = out_q.image_type;
  assign image_width_o  = out_q.image_width;
  assign image_height_o = out_q.image_height;

endmodule

@@ rtl/core/pnm_hdr_step.sv @@
// ----------------------------------------------------------------------------
// pnm_hdr_step
// Next-state logic of the header parser for one input transaction.
// ----------------------------------------------------------------------------
module pnm_hdr_step #(
  parameter int unsigned DIM_BITS = 16
) (
  input  pnm_hdr_pkg::hdr_ctrl_t ctrl_i,
  input  logic [DIM_BITS-1:0]    width_acc_i,
  input  logic [DIM_BITS-1:0]    height_acc_i,
  input  logic                   kind_i,
  input  logic [7:0]             data_byte_i,
  output pnm_hdr_pkg::hdr_ctrl_t ctrl_o,
  output logic [DIM_BITS-1:0]    width_acc_o,
  output logic [DIM_BITS-1:0]    height_acc_o
);
  import pnm_hdr_pkg::*;

  localparam int unsigned EXT_W = DIM_BITS + 4;

  logic                is_space;
  logic                is_digit;
  logic [DIM_BITS-1:0] acc_src;
  logic [EXT_W-1:0]    acc_ext;
  logic [EXT_W-1:0]    acc_prod;
  logic [DIM_BITS-1:0] acc_sat;

  always_comb begin
    is_space = data_byte_i inside {CH_SPACE, CH_TAB, CH_CR, CH_LF};
    is_digit = data_byte_i inside {[CH_0:CH_9]};
  end

  // One shared times-ten-plus-digit unit. A first digit starts from zero.
  always_comb begin
    case (ctrl_i.phase)
      PH_GAP1_MORE, PH_GAP2: acc_src = '0;
      PH_WIDTH:              acc_src = width_acc_i;
      default:               acc_src = height_acc_i;
    endcase
    acc_ext  = EXT_W'(acc_src);
    acc_prod = (acc_ext << 3) + (acc_ext << 1) + EXT_W'(data_byte_i[3:0]);
    if (|acc_prod[EXT_W-1:DIM_BITS]) begin
      acc_sat = '1;
    end else begin
      acc_sat = acc_prod[DIM_BITS-1:0];
    end
  end

  always_comb begin
    ctrl_o       = ctrl_i;
    width_acc_o  = width_acc_i;
    height_acc_o = height_acc_i;
    if (ctrl_i.verdict == ST_UNDECIDED) begin
      if (kind_i == KIND_EOD) begin
        ctrl_o.verdict = ST_BAD;
      end else if (ctrl_i.in_comment && data_byte_i != CH_LF) begin
        ctrl_o = ctrl_i;  // comment body dropped
      end else begin
        // newline closing a comment falls through as whitespace
        ctrl_o.in_comment = 1'b0;
        case (ctrl_i.phase)
          PH_MAGIC: begin
            ctrl_o.phase = PH_TYPE;
            if (data_byte_i != CH_P) ctrl_o.verdict = ST_BAD;
          end
          PH_TYPE: begin
            ctrl_o.phase = PH_GAP1;
            if (data_byte_i == CH_1 || data_byte_i == CH_4) begin
              ctrl_o.type_code = IMG_BITMAP;
            end else if (data_byte_i == CH_2 || data_byte_i == CH_5) begin
              ctrl_o.type_code = IMG_GRAYMAP;
            end else if (data_byte_i == CH_3 || data_byte_i == CH_6) begin
              ctrl_o.type_code = IMG_PIXMAP;
            end else begin
              ctrl_o.verdict = ST_BAD;
            end
          end
          PH_GAP1: begin
            if (data_byte_i == CH_HASH) begin
              ctrl_o.in_comment = 1'b1;
            end else begin
              ctrl_o.phase = PH_GAP1_MORE;
              if (!is_space) ctrl_o.verdict = ST_BAD;
            end
          end
          PH_GAP1_MORE: begin
            if (data_byte_i == CH_HASH) begin
              ctrl_o.in_comment = 1'b1;
            end else if (!is_space) begin
              if (is_digit) begin
                width_acc_o  = acc_sat;
                ctrl_o.phase = PH_WIDTH;
              end else begin
                ctrl_o.verdict = ST_BAD;
              end
            end
          end
          PH_WIDTH: begin
            if (is_digit) begin
              width_acc_o = acc_sat;
            end else if (is_space) begin
              ctrl_o.phase = PH_GAP2;
            end else begin
              ctrl_o.verdict = ST_BAD;
            end
          end
          PH_GAP2: begin
            if (!is_space) begin
              if (is_digit) begin
                height_acc_o = acc_sat;
                ctrl_o.phase = PH_HEIGHT;
              end else begin
                ctrl_o.verdict = ST_BAD;
              end
            end
          end
          PH_HEIGHT: begin
            if (is_digit) begin
              height_acc_o = acc_sat;
            end else if (is_space) begin
              ctrl_o.verdict = ST_GOOD;
            end else begin
              ctrl_o.verdict = ST_BAD;
            end
          end
          default: begin
            ctrl_o.verdict = ST_BAD;
          end
        endcase
      end
    end
  end

endmodule

@@ tb/hdr_stream_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hdr_stream_checker
// Watches both channels of the PNM header parser. It keeps its own model of
// the header state machine, predicts one result per accepted transaction and
// compares every accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module hdr_stream_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        kind_i,
  input  logic [7:0]  data_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  status_i,
  input  logic [1:0]  image_type_i,
  input  logic [15:0] image_width_i,
  input  logic [15:0] image_height_i,
  output int          err_count_o,
  output int          pending_o
);
  import pnm_hdr_pkg::*;

  // header model state
  phase_e    hdr_phase;
  logic      hdr_in_comment;
  status_e   hdr_verdict;
  img_type_e hdr_type;
  logic [DIM_OUT_W-1:0] width_acc;
  logic [DIM_OUT_W-1:0] height_acc;

  hdr_result_t expected_hdr_q[$];
  hdr_result_t want_hdr;

  initial err_count_o = 0;
  initial pending_o = 0;

  task automatic flag_mismatch(input string what, input int got, input int want);
    err_count_o++;
    $display("%0t MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  function automatic logic is_blank(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
  endfunction

  function automatic logic is_num(input logic [7:0] c);
    return c >= CH_0 && c <= CH_9;
  endfunction

  // acc * 10 + digit, clamped to the field maximum
  function automatic logic [DIM_OUT_W-1:0] times_ten_add(input logic [DIM_OUT_W-1:0] acc,
                                                        input logic [7:0] c);
    longint unsigned v;
    longint unsigned lim;
    lim = (64'd1 << DIM_OUT_W) - 1;
    v = longint'(acc) * 10 + longint'(c - CH_0);
    return (v > lim) ? lim[DIM_OUT_W-1:0] : v[DIM_OUT_W-1:0];
  endfunction

  task automatic step_header(input logic k, input logic [7:0] c);
    if (hdr_verdict != ST_UNDECIDED) return;
    if (k == KIND_EOD) begin
      hdr_verdict = ST_BAD;
      return;
    end
    if (hdr_in_comment) begin
      if (c != CH_LF) return;
      hdr_in_comment = 1'b0;  // newline falls through as whitespace
    end
    case (hdr_phase)
      PH_MAGIC: begin
        hdr_phase = PH_TYPE;
        if (c != CH_P) hdr_verdict = ST_BAD;
      end
      PH_TYPE: begin
        hdr_phase = PH_GAP1;
        if (c == CH_1 || c == CH_4) hdr_type = IMG_BITMAP;
        else if (c == CH_2 || c == CH_5) hdr_type = IMG_GRAYMAP;
        else if (c == CH_3 || c == CH_6) hdr_type = IMG_PIXMAP;
        else hdr_verdict = ST_BAD;
      end
      PH_GAP1: begin
        if (c == CH_HASH) begin
          hdr_in_comment = 1'b1;
        end else begin
          hdr_phase = PH_GAP1_MORE;
          if (!is_blank(c)) hdr_verdict = ST_BAD;
        end
      end
      PH_GAP1_MORE: begin
        if (c == CH_HASH) begin
          hdr_in_comment = 1'b1;
        end else if (is_num(c)) begin
          width_acc = times_ten_add('0, c);
          hdr_phase = PH_WIDTH;
        end else if (!is_blank(c)) begin
          hdr_verdict = ST_BAD;
        end
      end
      PH_WIDTH: begin
        if (is_num(c)) width_acc = times_ten_add(width_acc, c);
        else if (is_blank(c)) hdr_phase = PH_GAP2;
        else hdr_verdict = ST_BAD;
      end
      PH_GAP2: begin
        if (is_num(c)) begin
          height_acc = times_ten_add('0, c);
          hdr_phase = PH_HEIGHT;
        end else if (!is_blank(c)) begin
          hdr_verdict = ST_BAD;
        end
      end
      PH_HEIGHT: begin
        if (is_num(c)) height_acc = times_ten_add(height_acc, c);
        else if (is_blank(c)) hdr_verdict = ST_GOOD;
        else hdr_verdict = ST_BAD;
      end
      default: hdr_verdict = ST_BAD;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_phase      = PH_MAGIC;
      hdr_in_comment = 1'b0;
      hdr_verdict    = ST_UNDECIDED;
      hdr_type       = IMG_UNKNOWN;
      width_acc      = '0;
      height_acc     = '0;
      expected_hdr_q.delete();
      pending_o      = 0;
    end else begin
      // results first: a result never belongs to the byte taken at this edge
      if (out_valid_i && !out_stall_i) begin
        if (expected_hdr_q.size() == 0) begin
          flag_mismatch("unexpected result, status", status_i, 0);
        end else begin
          want_hdr = expected_hdr_q.pop_front();
          if (status_i != want_hdr.status)
            flag_mismatch("status", status_i, want_hdr.status);
          if (image_type_i != want_hdr.image_type)
            flag_mismatch("image_type", image_type_i, want_hdr.image_type);
          if (image_width_i != want_hdr.image_width)
            flag_mismatch("image_width", image_width_i, want_hdr.image_width);
          if (image_height_i != want_hdr.image_height)
            flag_mismatch("image_height", image_height_i, want_hdr.image_height);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        step_header(kind_i, data_byte_i);
        expected_hdr_q.push_back('{hdr_verdict, hdr_type, width_acc, height_acc});
      end
      pending_o = expected_hdr_q.size();
    end
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the PNM header parser.
// ----------------------------------------------------------------------------
// The block parses one file per reset and the run resets it only once, so the
// stream is a single long header: magic and a random type digit, a gap full
// of comments with random content (all byte values but newline), then width
// and height digits, often long enough to saturate. How the header ends is
// drawn at run time: good, a stray letter in the height, or end of data
// inside a comment. A tail of noise and end-of-data marks follows, all of
// which the block must ignore. Checking lives in hdr_stream_checker.
// ----------------------------------------------------------------------------
module tb_top;
  import pnm_hdr_pkg::*;

  localparam int          CYCLE_LIMIT   = 500000;
  localparam int          HOLD_AT_CYCLE = 1500;  // long receiver hold-off
  localparam int          HOLD_CYCLES   = 250;
  localparam int          COMMENT_ITEMS = 1450;  // bytes spent in the comment gap
  localparam logic [7:0]  CH_STRAY      = 8'h78; // 'x', never valid in a number

  // header endings, drawn once per run
  typedef enum int {END_EOD_IN_COMMENT, END_STRAY_BYTE, END_GOOD_A, END_GOOD_B} hdr_end_e;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        kind_i      = KIND_DATA;
  logic [7:0]  data_byte_i = 8'h00;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [1:0]  status_o;
  logic [1:0]  image_type_o;
  logic [15:0] image_width_o;
  logic [15:0] image_height_o;

  int err_count;
  int pending_cnt;
  int cycle_cnt   = 0;
  int n_sent      = 0;
  int stall_left  = 0;
  bit hold_done   = 1'b0;

  always #5 clk_i = ~clk_i;

  pnm_header_dimension_parser_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .data_byte_i    (data_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .image_type_o   (image_type_o),
    .image_width_o  (image_width_o),
    .image_height_o (image_height_o)
  );

  hdr_stream_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .kind_i         (kind_i),
    .data_byte_i    (data_byte_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_i       (status_o),
    .image_type_i   (image_type_o),
    .image_width_i  (image_width_o),
    .image_height_i (image_height_o),
    .err_count_o    (err_count),
    .pending_o      (pending_cnt)
  );

  // Cycle counter doubles as the watchdog.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones; every fourth stretch of 250
  // transactions runs back to back.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if ((n_sent / 250) % 4 == 1) return 0;
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 3))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  function automatic logic [7:0] pick_digit();
    return CH_0 + 8'($urandom_range(0, 9));
  endfunction

  // Any byte but newline, so a comment stays open.
  function automatic logic [7:0] pick_comment_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == CH_LF) b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  // Offer one transaction from a falling edge and return at the falling edge
  // after it is taken. Valid stays high between back-to-back transactions.
  task automatic offer(input logic k, input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    kind_i      <= k;
    data_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic offer_byte(input logic [7:0] b);
    offer(KIND_DATA, b);
  endtask

  // Receiver: random stalls, quiet stretches, and one long hold-off while
  // the sender keeps going so that the skid entry fills and in_stall_o rises.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (!hold_done && cycle_cnt >= HOLD_AT_CYCLE) begin
      hold_done   <= 1'b1;
      stall_left  <= HOLD_CYCLES - 1;
      out_stall_i <= 1'b1;
    end else if ((cycle_cnt / 400) % 3 == 0) begin
      out_stall_i <= 1'b0;
    end else if ($urandom_range(0, 99) < 60) begin
      out_stall_i <= 1'b0;
    end else begin
      stall_left  <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(9, 39);
      out_stall_i <= 1'b1;
    end
  end

  initial begin
    hdr_end_e ending;
    int       run_len;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed opening: magic, type, a comment in the first gap holding the
    // all-ones, all-zeros and '#' bytes, then every whitespace character.
    offer_byte(CH_P);
    offer_byte(CH_0 + 8'($urandom_range(1, 6)));
    offer_byte(CH_SPACE);
    offer_byte(CH_HASH);
    offer_byte(8'hFF);
    offer_byte(8'h00);
    offer_byte(CH_HASH);
    offer_byte(8'h80);
    offer_byte(CH_LF);      // ends the comment, then counts as whitespace
    offer_byte(CH_TAB);
    offer_byte(CH_CR);
    offer_byte(CH_LF);
    offer_byte(CH_HASH);    // comment opened right after a newline
    offer_byte(8'h7F);
    offer_byte(CH_LF);

    // Random comments with random content and whitespace between them.
    while (n_sent < COMMENT_ITEMS) begin
      offer_byte(CH_HASH);
      run_len = $urandom_range(0, 40);
      repeat (run_len) offer_byte(pick_comment_byte());
      offer_byte(CH_LF);
      run_len = $urandom_range(0, 2);
      repeat (run_len) offer_byte(pick_blank());
    end

    ending = hdr_end_e'($urandom_range(0, 3));
    if (ending == END_EOD_IN_COMMENT) begin
      offer_byte(CH_HASH);
      offer_byte(pick_comment_byte());
      offer(KIND_EOD, 8'($urandom_range(0, 255)));
    end else begin
      // Leading zero, then up to eight digits: often past the saturation point.
      offer_byte(CH_0);
      run_len = $urandom_range(1, 8);
      repeat (run_len) offer_byte(pick_digit());
      offer_byte(pick_blank());
      run_len = $urandom_range(0, 2);
      repeat (run_len) offer_byte(pick_blank());
      run_len = $urandom_range(1, 8);
      repeat (run_len) offer_byte(pick_digit());
      if (ending == END_STRAY_BYTE) offer_byte(CH_STRAY);
      else offer_byte(pick_blank());
    end

    // Decided from here on: noise and end-of-data marks must change nothing.
    repeat (40) offer(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    in_valid_i <= 1'b0;

    while (pending_cnt != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
